>>> rtl/tshf_pkg.sv
package tshf_pkg;

    localparam int TSHF_DEPTH_DEFAULT = 64;

    localparam int IN_DATA_W  = 216;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = 200;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 16;
    localparam int ACC_W      = 17;
    localparam int COUNT_OUT_W = 7;

    localparam logic [ACC_W-1:0]      ACC_MAX         = 17'h1FFFF;
    localparam logic [CFG_DATA_W-1:0] INTERVAL_RESET  = 16'd100;
    localparam logic [CFG_DATA_W-1:0] MAX_HIST_RESET  = 16'd3000;

    localparam logic [CFG_ADDR_W-1:0] REG_RECORD_INTERVAL = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_HISTORY     = 1'b1;

    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // stored snapshot, lowest field last
    typedef struct packed {
        logic [31:0]        t;
        logic [15:0]        health;
        logic signed [15:0] roll;
        logic signed [15:0] yaw;
        logic signed [15:0] pitch;
        logic signed [31:0] z;
        logic signed [31:0] y;
        logic signed [31:0] x;
    } snap_t;

    localparam int SNAP_W = $bits(snap_t);

    typedef struct packed {
        logic [6:0]         pad;
        logic [15:0]        health;
        logic signed [15:0] roll;
        logic signed [15:0] yaw;
        logic signed [15:0] pitch;
        logic signed [31:0] pos_z;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_x;
        logic [31:0]        now_ms;
        logic [15:0]        delta_ms;
        logic               may_record;
    } in_item_t;

    typedef struct packed {
        logic [31:0]        old_time_ms;
        logic [15:0]        old_health;
        logic signed [15:0] old_roll;
        logic signed [15:0] old_yaw;
        logic signed [15:0] old_pitch;
        logic signed [31:0] old_z;
        logic signed [31:0] old_y;
        logic signed [31:0] old_x;
        logic [6:0]         stored_count;
        logic               found;
    } out_item_t;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_ACC   = 7'b0000010,
        S_CMP   = 7'b0000100,
        S_PUSH  = 7'b0001000,
        S_READ  = 7'b0010000,
        S_CHECK = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

endpackage

>>> rtl/tshf_store.sv
module tshf_store
    import tshf_pkg::*;
#(
    parameter int STORE_DEPTH = TSHF_DEPTH_DEFAULT,
    parameter int IDX_W = $clog2(STORE_DEPTH)
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [IDX_W-1:0] waddr,
    input  snap_t            wdata,
    input  logic [IDX_W-1:0] raddr,
    output snap_t            rdata
);

    snap_t mem [STORE_DEPTH];
    snap_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/timed_snapshot_history_fifo.sv
// Time-windowed snapshot history.
// Input channel s_axis: tuser carries func (0 = tick, 1 = query), tdata the tick
// payload. A tick with may_record set adds delta_ms to a saturating 17-bit
// accumulator; once it reaches record_interval_ms one interval is taken off and a
// snapshot is pushed (dropping the oldest when full), then head entries older than
// max_history_ms relative to the new timestamp are evicted.
// Every item yields one result item on m_axis: the oldest snapshot, found flag and
// the stored count (all snapshot fields zero when empty).
// Config: cfg_we/cfg_addr/cfg_wdata, write only while no item is in flight.
// Sequence: a tick with may_record set passes S_ACC and S_CMP, then S_PUSH when
// an interval is due; every item then goes through S_READ and S_CHECK, which
// loop back to S_READ once per evicted entry, and ends in S_OUT. The snapshot
// memory's registered read is why S_READ comes before each age check.
// s_axis_tready is high only while the sequencer is idle, so a new item can be
// taken in the cycle after the result is loaded, and not while one is still
// being processed.
// A finished result sits in the output register; a new item can be accepted while
// it waits, but that item's result stalls until m_axis_tready takes the old one.
// Reset empties the store, clears the accumulator and restores the register defaults.
module timed_snapshot_history_fifo
    import tshf_pkg::*;
#(
    parameter int STORE_DEPTH = TSHF_DEPTH_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // may_record, delta_ms, now_ms, pos_x, pos_y, pos_z, pitch, yaw, roll, health, pad
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // func
    input  logic [IN_USER_W-1:0]  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // found, stored_count, old_x, old_y, old_z, old_pitch, old_yaw, old_roll,
    // old_health, old_time_ms
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int IDX_W = $clog2(STORE_DEPTH);
    localparam int CNT_W = $clog2(STORE_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    state_t state_reg, state_next;

    logic [CFG_DATA_W-1:0] interval_reg;
    logic [CFG_DATA_W-1:0] max_hist_reg;
    logic [ACC_W-1:0]      acc_reg, acc_next;
    logic [IDX_W-1:0]      head_reg, head_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  pushed_reg, pushed_next;
    in_item_t              item_reg;
    out_item_t             out_reg;
    logic                  out_valid_reg, out_valid_next;
    logic                  out_load;

    snap_t                 wr_snap;
    snap_t                 rd_snap;
    logic                  mem_we;
    logic [IDX_W-1:0]      slot;
    logic [SUM_W-1:0]      slot_sum;
    logic [ACC_W:0]        acc_sum;
    logic [ACC_W:0]        acc_diff;
    logic [31:0]           age;
    logic                  too_old;
    logic                  full;
    logic [IDX_W-1:0]      head_inc;
    logic                  in_fire;

    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);

    assign wr_snap = '{
        t:      item_reg.now_ms,
        health: item_reg.health,
        roll:   item_reg.roll,
        yaw:    item_reg.yaw,
        pitch:  item_reg.pitch,
        z:      item_reg.pos_z,
        y:      item_reg.pos_y,
        x:      item_reg.pos_x
    };

    assign full     = (count_reg == CNT_W'(STORE_DEPTH));
    assign head_inc = (head_reg == IDX_W'(STORE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign slot_sum = SUM_W'(head_reg) + SUM_W'(count_reg);
    always_comb
    begin
        if (full)
        begin
            slot = head_reg;
        end
        else if (slot_sum >= SUM_W'(STORE_DEPTH))
        begin
            slot = IDX_W'(slot_sum - SUM_W'(STORE_DEPTH));
        end
        else
        begin
            slot = IDX_W'(slot_sum);
        end
    end

    assign acc_sum  = {1'b0, acc_reg} + (ACC_W + 1)'(item_reg.delta_ms);
    assign acc_diff = {1'b0, acc_reg} - (ACC_W + 1)'(interval_reg);
    assign age      = item_reg.now_ms - rd_snap.t;
    assign too_old  = (age > 32'(max_hist_reg));
    assign mem_we   = (state_reg == S_PUSH);
    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || m_axis_tready);

    tshf_store #(
        .STORE_DEPTH (STORE_DEPTH),
        .IDX_W       (IDX_W)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (slot),
        .wdata (wr_snap),
        .raddr (head_reg),
        .rdata (rd_snap)
    );

    always_comb
    begin
        state_next  = state_reg;
        acc_next    = acc_reg;
        head_next   = head_reg;
        count_next  = count_reg;
        pushed_next = pushed_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    pushed_next = 1'b0;
                    if (s_axis_tuser[0] == FUNC_TICK && s_axis_tdata[0])
                    begin
                        state_next = S_ACC;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_ACC:
            begin
                acc_next   = acc_sum[ACC_W] ? ACC_MAX : acc_sum[ACC_W-1:0];
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (!acc_diff[ACC_W])
                begin
                    acc_next   = acc_diff[ACC_W-1:0];
                    state_next = S_PUSH;
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            S_PUSH:
            begin
                pushed_next = 1'b1;
                if (full)
                begin
                    head_next = head_inc;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                end
                state_next = S_READ;
            end
            S_READ:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                // the entry just pushed has age zero, so this stops before empty
                if (pushed_reg && too_old)
                begin
                    head_next  = head_inc;
                    count_next = count_reg - 1'b1;
                    state_next = S_READ;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            interval_reg  <= INTERVAL_RESET;
            max_hist_reg  <= MAX_HIST_RESET;
            acc_reg       <= '0;
            head_reg      <= '0;
            count_reg     <= '0;
            pushed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            pushed_reg    <= pushed_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_RECORD_INTERVAL: interval_reg <= cfg_wdata;
                    REG_MAX_HISTORY:     max_hist_reg <= cfg_wdata;
                    default:             interval_reg <= interval_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_reg <= in_item_t'(s_axis_tdata);
        end
        if (out_load)
        begin
            out_reg.stored_count <= COUNT_OUT_W'(count_reg);
            if (count_reg != '0)
            begin
                out_reg.found       <= 1'b1;
                out_reg.old_x       <= rd_snap.x;
                out_reg.old_y       <= rd_snap.y;
                out_reg.old_z       <= rd_snap.z;
                out_reg.old_pitch   <= rd_snap.pitch;
                out_reg.old_yaw     <= rd_snap.yaw;
                out_reg.old_roll    <= rd_snap.roll;
                out_reg.old_health  <= rd_snap.health;
                out_reg.old_time_ms <= rd_snap.t;
            end
            else
            begin
                out_reg.found       <= 1'b0;
                out_reg.old_x       <= '0;
                out_reg.old_y       <= '0;
                out_reg.old_z       <= '0;
                out_reg.old_pitch   <= '0;
                out_reg.old_yaw     <= '0;
                out_reg.old_roll    <= '0;
                out_reg.old_health  <= '0;
                out_reg.old_time_ms <= '0;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;

endmodule

>>> tb/tb_timed_snapshot_history_fifo.sv
module tb_timed_snapshot_history_fifo;
    timeunit 1ns;
    timeprecision 1ps;

    import tshf_pkg::*;

    localparam int DEPTH        = TSHF_DEPTH_DEFAULT;
    localparam int IW           = $clog2(DEPTH);
    localparam int IDLE_LIMIT   = 5000;
    localparam int DRAIN_CYCLES = 150;
    localparam int HOLD_CYCLES  = 400;
    localparam int N_PHASES     = 6;
    localparam out_item_t EMPTY_HEAD = '0;

    typedef struct packed {
        logic               func;
        logic               may_record;
        logic [15:0]        delta_ms;
        logic [31:0]        now_ms;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
        logic signed [15:0] roll;
        logic [15:0]        health;
    } stim_t;

    typedef struct packed {
        stim_t     it;
        logic      typed;
        out_item_t head;
    } dir_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // may_record, delta_ms, now_ms, pos_x, pos_y, pos_z, pitch, yaw, roll, health, pad
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    // func
    logic [IN_USER_W-1:0]  s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // found, stored_count, old_x, old_y, old_z, old_pitch, old_yaw, old_roll,
    // old_health, old_time_ms
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // history model state
    logic [ACC_W-1:0]      hist_acc = '0;
    snap_t                 hist_store [DEPTH];
    logic [IW-1:0]         hist_head = '0;
    logic [6:0]            hist_count = '0;
    logic [15:0]           cfg_interval = INTERVAL_RESET;
    logic [15:0]           cfg_max_hist = MAX_HIST_RESET;

    out_item_t expected_heads[$];

    int n_sent = 0;
    int n_recorded = 0;
    int n_full_drops = 0;
    int n_aged_out = 0;
    int peak_fill = 0;
    int n_errors = 0;
    int idle_cycles = 0;
    int rx_hold_req = 0;
    int burst_left = 0;

    timed_snapshot_history_fifo #(
        .STORE_DEPTH(DEPTH)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic stim_t mk(input logic func, input logic may, input logic [15:0] d,
                                 input logic [31:0] now, input logic [31:0] x,
                                 input logic [31:0] y, input logic [31:0] z,
                                 input logic [15:0] p, input logic [15:0] yw,
                                 input logic [15:0] r, input logic [15:0] h);
        stim_t s;
        s.func = func;
        s.may_record = may;
        s.delta_ms = d;
        s.now_ms = now;
        s.pos_x = x;
        s.pos_y = y;
        s.pos_z = z;
        s.pitch = p;
        s.yaw = yw;
        s.roll = r;
        s.health = h;
        return s;
    endfunction

    // Applies one item to the history and returns the head it leaves behind.
    function automatic out_item_t advance_history(input stim_t it);
        logic [ACC_W:0] sum;
        logic [IW-1:0]  slot;
        logic [31:0]    age;
        snap_t          s;
        out_item_t      r;
        if (it.func == FUNC_TICK && it.may_record)
        begin
            sum = hist_acc + it.delta_ms;
            if (sum > ACC_MAX)
                sum = ACC_MAX;
            if (sum >= cfg_interval)
            begin
                hist_acc = ACC_W'(sum - cfg_interval);
                s.x = it.pos_x;
                s.y = it.pos_y;
                s.z = it.pos_z;
                s.pitch = it.pitch;
                s.yaw = it.yaw;
                s.roll = it.roll;
                s.health = it.health;
                s.t = it.now_ms;
                if (hist_count == DEPTH)
                begin
                    hist_head++;
                    hist_count--;
                    n_full_drops++;
                end
                slot = hist_head + IW'(hist_count);
                hist_store[slot] = s;
                hist_count++;
                n_recorded++;
                age = s.t - hist_store[hist_head].t;
                while (hist_count != 0 && age > cfg_max_hist)
                begin
                    hist_head++;
                    hist_count--;
                    n_aged_out++;
                    age = s.t - hist_store[hist_head].t;
                end
                if (hist_count > peak_fill)
                    peak_fill = hist_count;
            end
            else
            begin
                hist_acc = ACC_W'(sum);
            end
        end
        r = '0;
        r.stored_count = hist_count;
        if (hist_count != 0)
        begin
            r.found = 1'b1;
            r.old_x = hist_store[hist_head].x;
            r.old_y = hist_store[hist_head].y;
            r.old_z = hist_store[hist_head].z;
            r.old_pitch = hist_store[hist_head].pitch;
            r.old_yaw = hist_store[hist_head].yaw;
            r.old_roll = hist_store[hist_head].roll;
            r.old_health = hist_store[hist_head].health;
            r.old_time_ms = hist_store[hist_head].t;
        end
        return r;
    endfunction

    task automatic send_item(input stim_t it, input logic typed, input out_item_t head);
        in_item_t  d;
        out_item_t predicted;
        int        gap;
        d = '0;
        d.may_record = it.may_record;
        d.delta_ms = it.delta_ms;
        d.now_ms = it.now_ms;
        d.pos_x = it.pos_x;
        d.pos_y = it.pos_y;
        d.pos_z = it.pos_z;
        d.pitch = it.pitch;
        d.yaw = it.yaw;
        d.roll = it.roll;
        d.health = it.health;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= d;
        s_axis_tuser <= it.func;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predicted = advance_history(it);
        expected_heads.push_back(typed ? head : predicted);
        n_sent++;
        // bursts with random gaps, a fair share of them back to back
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(9) < 3) ? 0 : $urandom_range(1, 10);
            if (gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (expected_heads.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic configure(input logic [15:0] interval, input logic [15:0] max_hist);
        cfg_we <= 1'b1;
        cfg_addr <= REG_RECORD_INTERVAL;
        cfg_wdata <= interval;
        @(posedge clk);
        cfg_interval = interval;
        cfg_addr <= REG_MAX_HISTORY;
        cfg_wdata <= max_hist;
        @(posedge clk);
        cfg_max_hist = max_hist;
        cfg_we <= 1'b0;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            n_errors++;
        end
    endtask

    // result side: compare against the oldest expected head, stall on a rotating pattern
    always @(posedge clk)
    begin : rx_side
        out_item_t   got;
        out_item_t   want;
        logic [15:0] rx_pattern;
        int          rx_phase_cnt;
        int          rx_hold_left;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata;
                if (expected_heads.size() == 0)
                begin
                    $error("unexpected result item: %0h", got);
                    n_errors++;
                end
                else
                begin
                    want = expected_heads.pop_front();
                    check_field("found", want.found, got.found);
                    check_field("stored_count", want.stored_count, got.stored_count);
                    check_field("old_x", want.old_x, got.old_x);
                    check_field("old_y", want.old_y, got.old_y);
                    check_field("old_z", want.old_z, got.old_z);
                    check_field("old_pitch", want.old_pitch, got.old_pitch);
                    check_field("old_yaw", want.old_yaw, got.old_yaw);
                    check_field("old_roll", want.old_roll, got.old_roll);
                    check_field("old_health", want.old_health, got.old_health);
                    check_field("old_time_ms", want.old_time_ms, got.old_time_ms);
                end
            end
            if (rx_hold_req != 0)
            begin
                rx_hold_left = rx_hold_req;
                rx_hold_req = 0;
            end
            if (rx_hold_left != 0)
            begin
                rx_hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                if (rx_phase_cnt <= 0)
                begin
                    rx_phase_cnt = $urandom_range(40, 120);
                    case ($urandom_range(3))
                        0: rx_pattern = '1;
                        1: rx_pattern = 16'($urandom);
                        2: rx_pattern = 16'b1100_1110_0111_0001;
                        default: rx_pattern = 16'b1111_0000_1101_1011;
                    endcase
                end
                rx_phase_cnt--;
                rx_pattern = {rx_pattern[0], rx_pattern[15:1]};
                m_axis_tready <= rx_pattern[0];
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        dir_row_t    dir_tab[$];
        out_item_t   first_head;
        stim_t       it;
        logic [31:0] world;
        int unsigned interval;
        int unsigned max_hist;
        int unsigned dmax;
        int unsigned n_items;
        int unsigned pick;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed items, default interval 100 ms and window 3000 ms
        first_head = '{old_time_ms: 32'd1000, old_health: 16'hFFFF, old_roll: 16'sd0,
                       old_yaw: -16'sd18000, old_pitch: 16'sd18000, old_z: -32'sd1,
                       old_y: 32'h8000_0000, old_x: 32'h7FFF_FFFF, stored_count: 7'd1,
                       found: 1'b1};
        dir_tab.push_back('{mk(FUNC_QUERY, 1'b1, '1, '1, '1, '1, '1, '1, '1, '1, '1),
                            1'b1, EMPTY_HEAD});
        dir_tab.push_back('{mk(FUNC_TICK, 1'b0, '1, '0, '0, '0, '0, '0, '0, '0, '0),
                            1'b1, EMPTY_HEAD});
        dir_tab.push_back('{mk(FUNC_TICK, 1'b1, 16'd50, 32'd500, 32'd1, 32'd2, 32'd3,
                               16'd1, 16'd2, 16'd3, 16'd4), 1'b1, EMPTY_HEAD});
        dir_tab.push_back('{mk(FUNC_TICK, 1'b1, 16'd50, 32'd1000, 32'h7FFF_FFFF,
                               32'h8000_0000, 32'hFFFF_FFFF, 16'sd18000, -16'sd18000,
                               16'sd0, 16'hFFFF), 1'b1, first_head});
        dir_tab.push_back('{mk(FUNC_QUERY, 1'b0, 16'd777, 32'd99, 32'd5, 32'd6, 32'd7,
                               16'd8, 16'd9, 16'd10, 16'd11), 1'b1, first_head});
        // age exactly equal to the window stays
        first_head.stored_count = 7'd2;
        dir_tab.push_back('{mk(FUNC_TICK, 1'b1, 16'd100, 32'd4000, 32'h8000_0000,
                               32'h7FFF_FFFF, 32'd0, -16'sd18000, 16'sd18000, -16'sd1,
                               16'd0), 1'b1, first_head});
        dir_tab.push_back('{mk(FUNC_TICK, 1'b1, 16'd100, 32'd4001, 32'h1234_5678,
                               32'hFEDC_BA98, 32'h0000_0100, 16'sd100, -16'sd100, 16'sd7,
                               16'd1600), 1'b0, EMPTY_HEAD});
        // large delta leaves a backlog that records on following ticks
        dir_tab.push_back('{mk(FUNC_TICK, 1'b1, 16'hFFFF, 32'd5000, 32'hFFFF_FF00,
                               32'h0000_00FF, 32'h4000_0000, 16'sd0, 16'sd0, 16'sd18000,
                               16'h8000), 1'b0, EMPTY_HEAD});
        dir_tab.push_back('{mk(FUNC_TICK, 1'b1, 16'd0, 32'd5000, 32'd11, 32'd12, 32'd13,
                               16'sd1, 16'sd2, 16'sd3, 16'd5), 1'b0, EMPTY_HEAD});
        dir_tab.push_back('{mk(FUNC_TICK, 1'b1, 16'd0, 32'hFFFF_FFF0, 32'd21, 32'd22,
                               32'd23, -16'sd1, -16'sd2, -16'sd3, 16'd6), 1'b0, EMPTY_HEAD});
        dir_tab.push_back('{mk(FUNC_TICK, 1'b1, 16'd0, 32'h0000_0010, 32'd31, 32'd32,
                               32'd33, 16'sd4, 16'sd5, -16'sd18000, 16'd7), 1'b0, EMPTY_HEAD});
        dir_tab.push_back('{mk(FUNC_QUERY, 1'b1, 16'hFFFF, 32'd0, '1, '0, '1, '0, '1, '0,
                               '1), 1'b0, EMPTY_HEAD});
        dir_tab.push_back('{mk(FUNC_TICK, 1'b0, 16'hFFFF, 32'h0000_5000, '0, '1, '0, '1,
                               '0, '1, '0), 1'b0, EMPTY_HEAD});
        foreach (dir_tab[i])
            send_item(dir_tab[i].it, dir_tab[i].typed, dir_tab[i].head);
        drain_results();

        world = 32'h0000_5000;
        for (int p = 0; p < N_PHASES; p++)
        begin
            case (p)
                0:
                begin
                    interval = 1;
                    max_hist = 65535;
                    dmax = 600;
                    n_items = 90;
                end
                1:
                begin
                    interval = 1;
                    max_hist = 65535;
                    dmax = 65535;
                    n_items = 25;
                end
                2:
                begin
                    interval = 65535;
                    max_hist = 0;
                    dmax = 65535;
                    n_items = 50;
                end
                3:
                begin
                    interval = 0;
                    max_hist = 0;
                    dmax = 3;
                    n_items = 60;
                end
                4:
                begin
                    interval = INTERVAL_RESET;
                    max_hist = MAX_HIST_RESET;
                    dmax = 250;
                    n_items = 90;
                end
                default:
                begin
                    interval = $urandom_range(1, 3000);
                    max_hist = $urandom_range(65535);
                    dmax = 2 * interval;
                    n_items = 120;
                    world = 32'hFFFF_0000 + $urandom_range(60000);
                end
            endcase
            configure(16'(interval), 16'(max_hist));
            // long receiver stall while items keep coming
            if (p == 0)
                rx_hold_req = HOLD_CYCLES;
            repeat (n_items)
            begin
                pick = $urandom_range(99);
                it.func = FUNC_TICK;
                it.may_record = 1'b1;
                it.pos_x = $urandom;
                it.pos_y = $urandom;
                it.pos_z = $urandom;
                it.pitch = 16'($urandom_range(36000)) - 16'd18000;
                it.yaw = 16'($urandom_range(36000)) - 16'd18000;
                it.roll = 16'($urandom_range(36000)) - 16'd18000;
                it.health = 16'($urandom);
                if (pick < 72)
                begin
                    it.delta_ms = 16'($urandom_range(dmax));
                    world += it.delta_ms;
                    it.now_ms = world;
                end
                else if (pick < 82)
                begin
                    it.may_record = 1'b0;
                    it.delta_ms = 16'($urandom);
                    it.now_ms = world;
                end
                else if (pick < 92)
                begin
                    it.func = FUNC_QUERY;
                    it.may_record = 1'($urandom);
                    it.delta_ms = 16'($urandom);
                    it.now_ms = $urandom;
                end
                else
                begin
                    it.delta_ms = 16'($urandom);
                    world = $urandom;
                    it.now_ms = world;
                end
                send_item(it, 1'b0, EMPTY_HEAD);
            end
            drain_results();
        end

        $display("%0d items over %0d register settings, incl. zero interval and time wrap",
                 n_sent, N_PHASES + 1);
        $display("%0d snapshots recorded, %0d dropped when full, %0d aged out, peak fill %0d",
                 n_recorded, n_full_drops, n_aged_out, peak_fill);
        if (n_errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
